[hw/rtl/cpuid_pkg.sv]
// ----------------------------------------------------------------------------
// cpuid_pkg
// Shared types, register indexes, phase codes and decode helpers for the
// load/inc/dec CPU core.
// ----------------------------------------------------------------------------
package cpuid_pkg;

  localparam logic [2:0] PhFetch    = 3'd0;
  localparam logic [2:0] PhImmLo    = 3'd1;
  localparam logic [2:0] PhImmHi    = 3'd2;
  localparam logic [2:0] PhImm8     = 3'd3;
  localparam logic [2:0] PhMemRead  = 3'd4;
  localparam logic [2:0] PhMemWrite = 3'd5;

  localparam logic [2:0] RegB = 3'd0;
  localparam logic [2:0] RegD = 3'd2;
  localparam logic [2:0] RegH = 3'd4;
  localparam logic [2:0] RegL = 3'd5;
  localparam logic [2:0] RegA = 3'd6;

  localparam logic [7:0] FlagZ = 8'h80;
  localparam logic [7:0] FlagN = 8'h40;
  localparam logic [7:0] FlagH = 8'h20;

  localparam logic [7:0] OpNop     = 8'h00;
  localparam logic [7:0] OpHalt    = 8'h76;
  localparam logic [7:0] OpIncHlm  = 8'h34;
  localparam logic [7:0] OpDecHlm  = 8'h35;
  localparam logic [7:0] OpLdHlmN  = 8'h36;
  localparam logic [7:0] OpLdAbsA  = 8'hea;
  localparam logic [7:0] OpLdAAbs  = 8'hfa;
  localparam logic [7:0] OpLdAHli  = 8'h2a;
  localparam logic [7:0] OpLdAHld  = 8'h3a;
  localparam logic [7:0] OpLdBcA   = 8'h02;
  localparam logic [7:0] OpLdDeA   = 8'h12;
  localparam logic [7:0] OpLdHliA  = 8'h22;
  localparam logic [7:0] OpLdHldA  = 8'h32;
  localparam logic [7:0] OpIncSp   = 8'h33;
  localparam logic [7:0] OpLdSpNn  = 8'h31;

  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        done;
    logic [4:0]  cyc;
    logic        halt;
    logic        inv;
  } bus_req_t;

  // Map a 3-bit register code to the register file index (code 7 is A).
  function automatic logic [2:0] reg_index(input logic [2:0] code);
    reg_index = (code >= 3'd6) ? RegA : code;
  endfunction

  function automatic logic [4:0] cycle_count(input logic [7:0] op);
    logic [4:0] c;
    c = 5'd4;
    if (op == OpLdAbsA || op == OpLdAAbs) begin
      c = 5'd16;
    end else if ((op & 8'hcf) == 8'h01 || op == OpIncHlm || op == OpDecHlm
                 || op == OpLdHlmN) begin
      c = 5'd12;
    end else if ((op & 8'hcf) == 8'h03 || (op & 8'hc7) == 8'h06) begin
      c = 5'd8;
    end else if (op == OpLdBcA || op == OpLdDeA || op == OpLdHliA || op == OpLdHldA
                 || op == OpLdAHli || op == OpLdAHld) begin
      c = 5'd8;
    end else if (op[7:6] == 2'b01 && op != OpHalt
                 && (op[2:0] == 3'd6 || op[5:3] == 3'd6)) begin
      c = 5'd8;
    end
    cycle_count = c;
  endfunction

endpackage

[hw/rtl/cpuid_alu.sv]
// ----------------------------------------------------------------------------
// cpuid_alu
// 8-bit increment/decrement with Z, N and H flag update.
// ----------------------------------------------------------------------------
module cpuid_alu import cpuid_pkg::*; (
  input  logic [7:0] val_i,
  input  logic       dec_i,
  input  logic [7:0] flags_i,
  output logic [7:0] res_o,
  output logic [7:0] flags_o
);

  logic [7:0] f;

  always_comb begin
    res_o = dec_i ? val_i - 8'd1 : val_i + 8'd1;
    f = flags_i & ~(FlagZ | FlagN | FlagH);
    if (res_o == 8'd0) f = f | FlagZ;
    if (dec_i) f = f | FlagN;
    if (dec_i ? (res_o[3:0] == 4'hf) : (res_o[3:0] == 4'h0)) f = f | FlagH;
    flags_o = f;
  end

endmodule

[hw/rtl/cpu_load_incdec_core.sv]
// ----------------------------------------------------------------------------
// cpu_load_incdec_core
// Bus-cycle CPU core for a load / inc / dec opcode subset.
// ----------------------------------------------------------------------------
// Each input beat on read_data_i is the completion of one bus cycle; each
// output beat is the request for the next bus cycle plus instruction status.
// One input beat produces exactly one output beat.
// A result beat is registered: it appears the cycle after its input is accepted.
// Throughput: one beat per cycle unless the output stalls; the architectural
// state and the output register update in the same cycle, fed by one decode pass.
// The input stalls only when the output register is full and stalled, so a
// receiver stall back-pressures the source directly and nothing is dropped.
// At reset all state registers but the result register are zero and an
// opcode fetch at address 0 is taken as outstanding; the first input beat is that opcode byte.
// An unknown opcode stops the core: every later beat requests a read at the
// program counter with invalid_opcode_o set, until reset.
// ----------------------------------------------------------------------------
module cpu_load_incdec_core import cpuid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] bus_address_o,
  output logic        bus_write_o,
  output logic [7:0]  write_data_o,
  output logic        instr_done_o,
  output logic [4:0]  instr_cycles_o,
  output logic        halt_seen_o,
  output logic        invalid_opcode_o
);

  logic [15:0] pc_q, pc_d, sp_q, sp_d;
  logic [7:0]  regs_q [7];
  logic [7:0]  regs_d [7];
  logic [7:0]  flags_q, flags_d, op_q, op_d, lo_q, lo_d;
  logic [2:0]  ph_q, ph_d;
  logic        stop_q, stop_d;
  logic        ovalid_q;
  bus_req_t    req_q, req_d;
  logic        accept;

  logic [7:0]  alu_in, alu_res, alu_flags;
  logic        alu_dec;

  assign in_stall_o = ovalid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  cpuid_alu u_alu (
    .val_i  (alu_in),
    .dec_i  (alu_dec),
    .flags_i(flags_q),
    .res_o  (alu_res),
    .flags_o(alu_flags)
  );

  logic [15:0] hl, imm16;
  logic [7:0]  rd;
  logic [2:0]  dst, src;

  always_comb begin
    rd    = read_data_i;
    hl    = {regs_q[RegH], regs_q[RegL]};
    imm16 = {rd, lo_q};
    dst   = reg_index(rd[5:3]);
    src   = reg_index(rd[2:0]);
    // ALU operand: memory byte in the memory-read phase, register otherwise
    alu_dec = (ph_q == PhMemRead) ? (op_q == OpDecHlm) : rd[0];
    alu_in  = (ph_q == PhMemRead) ? rd : regs_q[dst];

    pc_d = pc_q; sp_d = sp_q; flags_d = flags_q; op_d = op_q; lo_d = lo_q;
    ph_d = ph_q; stop_d = stop_q;
    for (int i = 0; i < 7; i++) regs_d[i] = regs_q[i];
    req_d = '0;
    req_d.addr = pc_q;

    if (stop_q) begin
      req_d.inv = 1'b1;
    end else begin
      unique case (ph_q)
        PhImmLo: begin
          lo_d = rd;
          pc_d = pc_q + 16'd1;
          req_d.addr = pc_d;
          ph_d = PhImmHi;
        end
        PhImmHi: begin
          pc_d = pc_q + 16'd1;
          req_d.addr = pc_d;
          ph_d = PhFetch;
          if (op_q == OpLdAbsA) begin
            req_d.addr = imm16; req_d.wr = 1'b1; req_d.wdata = regs_q[RegA];
            ph_d = PhMemWrite;
          end else if (op_q == OpLdAAbs) begin
            req_d.addr = imm16; ph_d = PhMemRead;
          end else begin
            if (op_q == OpLdSpNn) sp_d = imm16;
            else begin
              regs_d[{op_q[5:4], 1'b0}] = rd;
              regs_d[{op_q[5:4], 1'b1}] = lo_q;
            end
            req_d.done = 1'b1;
          end
        end
        PhImm8: begin
          pc_d = pc_q + 16'd1;
          req_d.addr = pc_d;
          ph_d = PhFetch;
          if (op_q == OpLdHlmN) begin
            req_d.addr = hl; req_d.wr = 1'b1; req_d.wdata = rd; ph_d = PhMemWrite;
          end else begin
            regs_d[reg_index(op_q[5:3])] = rd;
            req_d.done = 1'b1;
          end
        end
        PhMemRead: begin
          if (op_q == OpIncHlm || op_q == OpDecHlm) begin
            req_d.addr = hl; req_d.wr = 1'b1; req_d.wdata = alu_res;
            flags_d = alu_flags; ph_d = PhMemWrite;
          end else begin
            if (op_q == OpLdAAbs || op_q == OpLdAHli || op_q == OpLdAHld)
              regs_d[RegA] = rd;
            else
              regs_d[reg_index(op_q[5:3])] = rd;
            req_d.done = 1'b1; ph_d = PhFetch;
          end
        end
        PhMemWrite: begin
          req_d.done = 1'b1; ph_d = PhFetch;
        end
        default: begin
          op_d = rd;
          pc_d = pc_q + 16'd1;
          req_d.addr = pc_d;
          ph_d = PhFetch;
          priority if (rd == OpNop || rd == OpHalt) begin
            req_d.done = 1'b1;
          end else if ((rd & 8'hcf) == 8'h01 || rd == OpLdAbsA || rd == OpLdAAbs) begin
            ph_d = PhImmLo;
          end else if (rd == OpIncHlm || rd == OpDecHlm || rd == OpLdAHli
                       || rd == OpLdAHld) begin
            if (rd == OpLdAHli) {regs_d[RegH], regs_d[RegL]} = hl + 16'd1;
            if (rd == OpLdAHld) {regs_d[RegH], regs_d[RegL]} = hl - 16'd1;
            req_d.addr = hl; ph_d = PhMemRead;
          end else if ((rd & 8'hc6) == 8'h04) begin
            regs_d[dst] = alu_res; flags_d = alu_flags; req_d.done = 1'b1;
          end else if ((rd & 8'hcf) == 8'h03) begin
            if (rd == OpIncSp) sp_d = sp_q + 16'd1;
            else {regs_d[{rd[5:4], 1'b0}], regs_d[{rd[5:4], 1'b1}]} =
                   {regs_q[{rd[5:4], 1'b0}], regs_q[{rd[5:4], 1'b1}]} + 16'd1;
            req_d.done = 1'b1;
          end else if ((rd & 8'hc7) == 8'h06) begin
            ph_d = PhImm8;
          end else if (rd[7:6] == 2'b01) begin
            if (rd[5:3] == 3'd6) begin
              req_d.addr = hl; req_d.wr = 1'b1; req_d.wdata = regs_q[src];
              ph_d = PhMemWrite;
            end else if (rd[2:0] == 3'd6) begin
              req_d.addr = hl; ph_d = PhMemRead;
            end else begin
              regs_d[dst] = regs_q[src]; req_d.done = 1'b1;
            end
          end else if (rd == OpLdBcA || rd == OpLdDeA) begin
            req_d.addr = (rd == OpLdBcA) ? {regs_q[RegB], regs_q[RegB + 3'd1]}
                                         : {regs_q[RegD], regs_q[RegD + 3'd1]};
            req_d.wr = 1'b1; req_d.wdata = regs_q[RegA]; ph_d = PhMemWrite;
          end else if (rd == OpLdHliA || rd == OpLdHldA) begin
            {regs_d[RegH], regs_d[RegL]} = (rd == OpLdHliA) ? hl + 16'd1 : hl - 16'd1;
            req_d.addr = hl; req_d.wr = 1'b1; req_d.wdata = regs_q[RegA];
            ph_d = PhMemWrite;
          end else begin
            stop_d = 1'b1; req_d.done = 1'b1; req_d.inv = 1'b1;
          end
        end
      endcase
      if (req_d.done && !req_d.inv) begin
        req_d.cyc  = cycle_count(op_d);
        req_d.halt = (op_d == OpHalt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; sp_q <= '0; flags_q <= '0; op_q <= '0; lo_q <= '0;
      ph_q <= PhFetch; stop_q <= 1'b0; ovalid_q <= 1'b0;
      for (int i = 0; i < 7; i++) regs_q[i] <= '0;
    end else begin
      if (accept) begin
        pc_q <= pc_d; sp_q <= sp_d; flags_q <= flags_d; op_q <= op_d; lo_q <= lo_d;
        ph_q <= ph_d; stop_q <= stop_d;
        for (int i = 0; i < 7; i++) regs_q[i] <= regs_d[i];
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Result register: load on every accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_d;
  end

  assign out_valid_o      = ovalid_q;
  assign bus_address_o    = req_q.addr;
  assign bus_write_o      = req_q.wr;
  assign write_data_o     = req_q.wdata;
  assign instr_done_o     = req_q.done;
  assign instr_cycles_o   = req_q.cyc;
  assign halt_seen_o      = req_q.halt;
  assign invalid_opcode_o = req_q.inv;

endmodule
